[rtl/imuoc_pkg.sv]
package imuoc_pkg;

	localparam int NUM_AXES          = 6;
	localparam int AXIS_W            = 3;
	localparam int SAMPLE_W          = 16;
	localparam int SUM_W             = 26;
	// Largest round sum magnitude is 500 * 32768, which fits 25 bits.
	localparam int MAG_W             = 25;
	localparam int SAMPLES_PER_ROUND = 500;
	localparam int CNT_W             = 9;
	// A mean never exceeds 32768 in magnitude.
	localparam int QUO_W             = 17;
	// Deviation covers mean minus up to 32767 counts of gravity.
	localparam int DEV_W             = 18;
	localparam int TOL_W             = 8;
	localparam int GRAV_W            = 15;

	// Reciprocal of the round length, rounded up. With the shift at least MAG_W plus the
	// bits of the round length, the rounding error times any dividend below 2**MAG_W stays
	// under one unit of the shift, so the shifted product is the exact quotient.
	localparam int     RECIP_SHIFT = MAG_W + CNT_W;
	localparam longint RECIP_L     = ((longint'(1) << RECIP_SHIFT) + SAMPLES_PER_ROUND - 1)
		/ SAMPLES_PER_ROUND;
	localparam int     RECIP_W     = $clog2(RECIP_L + 1);
	localparam int     PROD_W      = MAG_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

	localparam logic [CNT_W:0]    ROUND_LEN   = (CNT_W + 1)'(SAMPLES_PER_ROUND);

	// Axis order: accel X, Y, Z, gyro X, Y, Z.
	localparam logic [AXIS_W-1:0] AXIS_FIRST   = 3'd0;
	localparam logic [AXIS_W-1:0] AXIS_ACCEL_Z = 3'd2;
	localparam logic [AXIS_W-1:0] AXIS_GYRO_X  = 3'd3;
	localparam logic [AXIS_W-1:0] AXIS_LAST    = AXIS_W'(NUM_AXES - 1);

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_GYRO_TOL  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_TOL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY   = 2'd2;

	localparam logic [TOL_W-1:0]  GYRO_TOL_RST  = 8'd1;
	localparam logic [TOL_W-1:0]  ACCEL_TOL_RST = 8'd5;
	localparam logic [GRAV_W-1:0] GRAVITY_RST   = 15'd16384;

	typedef logic [NUM_AXES-1:0][SAMPLE_W-1:0] axis_vec_t;

	typedef struct packed {
		logic               capture;
		logic               clear;
		logic               corr_en;
		logic               sum_en;
		logic               upd_en;
		logic               first;
		logic [AXIS_W-1:0]  axis;
	} dp_ctrl_t;

endpackage

[rtl/imuoc_div.sv]
// Divides by the fixed round length with one multiply by its reciprocal; the quotient
// is registered and flagged done on the cycle after start.
module imuoc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [imuoc_pkg::MAG_W-1:0]   dividend,
	output logic                          done,
	output logic [imuoc_pkg::QUO_W-1:0]   quo
);

	logic [imuoc_pkg::PROD_W-1:0] prod;
	logic                         done_q;
	logic [imuoc_pkg::QUO_W-1:0]  quo_q;

	assign prod = {{imuoc_pkg::RECIP_W{1'b0}}, dividend}
		* {{imuoc_pkg::MAG_W{1'b0}}, imuoc_pkg::RECIP};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= prod[imuoc_pkg::RECIP_SHIFT +: imuoc_pkg::QUO_W];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

[rtl/imuoc_dp.sv]
// Per-axis storage with one shared 16-bit adder for correction and offset update.
module imuoc_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  imuoc_pkg::dp_ctrl_t            ctrl,
	input  imuoc_pkg::axis_vec_t           raw_in,
	input  logic [imuoc_pkg::TOL_W-1:0]    accel_tol,
	input  logic [imuoc_pkg::TOL_W-1:0]    gyro_tol,
	input  logic [imuoc_pkg::GRAV_W-1:0]   grav,
	input  logic [imuoc_pkg::QUO_W-1:0]    quo,
	output imuoc_pkg::axis_vec_t           corr,
	output logic [imuoc_pkg::MAG_W-1:0]    sum_mag,
	output logic                           pass
);

	imuoc_pkg::axis_vec_t raw_q;
	imuoc_pkg::axis_vec_t off_q;
	imuoc_pkg::axis_vec_t corr_q;
	logic [imuoc_pkg::NUM_AXES-1:0][imuoc_pkg::SUM_W-1:0] sum_q;

	logic [imuoc_pkg::SAMPLE_W-1:0] off_sel;
	logic [imuoc_pkg::SAMPLE_W-1:0] add_a;
	logic [imuoc_pkg::SAMPLE_W-1:0] add_b;
	logic [imuoc_pkg::SAMPLE_W-1:0] add_y;
	logic [imuoc_pkg::SUM_W-1:0]    sum_sel;
	logic [imuoc_pkg::SUM_W-1:0]    sum_abs;
	logic [imuoc_pkg::SUM_W-1:0]    sum_next;
	logic                           sum_neg;
	logic [imuoc_pkg::DEV_W-1:0]    q_ext;
	logic [imuoc_pkg::DEV_W-1:0]    mean;
	logic [imuoc_pkg::DEV_W-1:0]    dev;
	logic [imuoc_pkg::DEV_W-1:0]    dev_abs;
	logic [imuoc_pkg::TOL_W-1:0]    tol;

	assign off_sel = off_q[ctrl.axis];

	// Correction is raw minus offset; the update is offset plus deviation.
	assign add_a = ctrl.upd_en ? dev[imuoc_pkg::SAMPLE_W-1:0] : raw_q[ctrl.axis];
	assign add_b = ctrl.upd_en ? off_sel : ~off_sel;
	assign add_y = add_a + add_b + {{(imuoc_pkg::SAMPLE_W-1){1'b0}}, !ctrl.upd_en};

	assign sum_sel  = sum_q[ctrl.axis];
	assign sum_neg  = sum_sel[imuoc_pkg::SUM_W-1];
	assign sum_abs  = sum_neg ? (~sum_sel + 1'b1) : sum_sel;
	assign sum_mag  = sum_abs[imuoc_pkg::MAG_W-1:0];
	assign sum_next = sum_sel
		+ {{(imuoc_pkg::SUM_W-imuoc_pkg::SAMPLE_W){add_y[imuoc_pkg::SAMPLE_W-1]}}, add_y};

	// The mean truncates toward zero, so the sign is applied after division.
	assign q_ext   = {1'b0, quo};
	assign mean    = sum_neg ? (~q_ext + 1'b1) : q_ext;
	assign dev     = (ctrl.axis == imuoc_pkg::AXIS_ACCEL_Z)
		? mean - {{(imuoc_pkg::DEV_W-imuoc_pkg::GRAV_W){1'b0}}, grav} : mean;
	assign dev_abs = dev[imuoc_pkg::DEV_W-1] ? (~dev + 1'b1) : dev;
	assign tol     = (ctrl.axis < imuoc_pkg::AXIS_GYRO_X) ? accel_tol : gyro_tol;
	assign pass    = dev_abs < {{(imuoc_pkg::DEV_W-imuoc_pkg::TOL_W){1'b0}}, tol};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0;
			sum_q <= '0;
		end else if (ctrl.clear) begin
			off_q <= '0;
			sum_q <= '0;
		end else begin
			if (ctrl.corr_en && ctrl.sum_en) begin
				sum_q[ctrl.axis] <= sum_next;
			end
			if (ctrl.upd_en) begin
				sum_q[ctrl.axis] <= '0;
				if (ctrl.first) begin
					off_q[ctrl.axis] <= dev[imuoc_pkg::SAMPLE_W-1:0];
				end else if (!pass) begin
					off_q[ctrl.axis] <= add_y;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			raw_q <= raw_in;
		end
		if (ctrl.corr_en) begin
			corr_q[ctrl.axis] <= add_y;
		end
	end

	assign corr = corr_q;

endmodule

[rtl/imu_offset_calibrator.sv]
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_stall    action, accel_x..z, gyro_x..z
// out       output     out_valid / out_stall  corr_accel_x..z, corr_gyro_x..z, flags
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A sample transaction is accepted, runs the axis loop through the shared adder, is
// counted and then loads the output register.
// The last sample of a round adds, for each axis, a state to start the divide by the
// round length, one while the reciprocal-multiply quotient is registered, and one for
// the offset update.
// A start transaction is absorbed in its acceptance cycle and returns no result.
// in_stall is high while an item is being worked on; a finished result waits in the
// output register, so the next item may be accepted while out_stall holds it.
// Reset clears the offsets, sums, round count and internal state flags (not the held output
// flags) and restores the register defaults; the configuration port is always ready.
module imu_offset_calibrator (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  action,
	input  logic signed [imuoc_pkg::SAMPLE_W-1:0] accel_x,
	input  logic signed [imuoc_pkg::SAMPLE_W-1:0] accel_y,
	input  logic signed [imuoc_pkg::SAMPLE_W-1:0] accel_z,
	input  logic signed [imuoc_pkg::SAMPLE_W-1:0] gyro_x,
	input  logic signed [imuoc_pkg::SAMPLE_W-1:0] gyro_y,
	input  logic signed [imuoc_pkg::SAMPLE_W-1:0] gyro_z,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [imuoc_pkg::SAMPLE_W-1:0] corr_accel_x,
	output logic signed [imuoc_pkg::SAMPLE_W-1:0] corr_accel_y,
	output logic signed [imuoc_pkg::SAMPLE_W-1:0] corr_accel_z,
	output logic signed [imuoc_pkg::SAMPLE_W-1:0] corr_gyro_x,
	output logic signed [imuoc_pkg::SAMPLE_W-1:0] corr_gyro_y,
	output logic signed [imuoc_pkg::SAMPLE_W-1:0] corr_gyro_z,
	output logic                                  calibrating,
	output logic                                  calibration_done,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [imuoc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [imuoc_pkg::GRAV_W-1:0]          cfg_data
);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_CORR    = 3'd1;
	localparam logic [2:0] ST_COUNT   = 3'd2;
	localparam logic [2:0] ST_DIV     = 3'd3;
	localparam logic [2:0] ST_WAIT    = 3'd4;
	localparam logic [2:0] ST_UPD     = 3'd5;
	localparam logic [2:0] ST_DELIVER = 3'd6;

	logic [2:0]                       state_q;
	logic [imuoc_pkg::AXIS_W-1:0]     axis_q;
	logic [imuoc_pkg::CNT_W-1:0]      cnt_q;
	logic                             active_q;
	logic                             first_q;
	logic                             finished_q;
	logic                             all_pass_q;
	logic [imuoc_pkg::TOL_W-1:0]      gyro_tol_q;
	logic [imuoc_pkg::TOL_W-1:0]      accel_tol_q;
	logic [imuoc_pkg::GRAV_W-1:0]     grav_q;
	logic                             out_valid_q;
	imuoc_pkg::axis_vec_t             out_corr_q;
	logic                             out_cal_q;
	logic                             out_done_q;

	logic                             in_take;
	logic                             out_take;
	logic                             out_load;
	logic [imuoc_pkg::CNT_W:0]        cnt_inc;
	logic                             round_end;
	imuoc_pkg::dp_ctrl_t              ctrl;
	imuoc_pkg::axis_vec_t             raw_in;
	imuoc_pkg::axis_vec_t             corr;
	logic [imuoc_pkg::MAG_W-1:0]      sum_mag;
	logic                             pass;
	logic                             div_start;
	logic                             div_done;
	logic [imuoc_pkg::QUO_W-1:0]      quo;

	assign in_stall  = state_q != ST_IDLE;
	assign in_take   = in_valid && !in_stall;
	assign out_take  = out_valid_q && !out_stall;
	// The output register is loaded only when it is empty or being emptied now.
	assign out_load  = (state_q == ST_DELIVER) && (!out_valid_q || !out_stall);
	assign cnt_inc   = {1'b0, cnt_q} + 1'b1;
	assign round_end = cnt_inc >= imuoc_pkg::ROUND_LEN;
	assign div_start = state_q == ST_DIV;
	assign cfg_ready = 1'b1;

	assign raw_in = {gyro_z, gyro_y, gyro_x, accel_z, accel_y, accel_x};

	always_comb begin
		ctrl         = '0;
		ctrl.axis    = axis_q;
		ctrl.first   = first_q;
		ctrl.capture = in_take && !action;
		ctrl.clear   = in_take && action;
		ctrl.corr_en = state_q == ST_CORR;
		ctrl.sum_en  = active_q;
		ctrl.upd_en  = state_q == ST_UPD;
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gyro_tol_q  <= imuoc_pkg::GYRO_TOL_RST;
			accel_tol_q <= imuoc_pkg::ACCEL_TOL_RST;
			grav_q      <= imuoc_pkg::GRAVITY_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				imuoc_pkg::CFG_GYRO_TOL: begin
					gyro_tol_q <= cfg_data[imuoc_pkg::TOL_W-1:0];
				end
				imuoc_pkg::CFG_ACCEL_TOL: begin
					accel_tol_q <= cfg_data[imuoc_pkg::TOL_W-1:0];
				end
				imuoc_pkg::CFG_GRAVITY: begin
					grav_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// Sequencer: the axis loop, round bookkeeping and the per-axis divide and update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			axis_q     <= imuoc_pkg::AXIS_FIRST;
			cnt_q      <= '0;
			active_q   <= 1'b0;
			first_q    <= 1'b0;
			finished_q <= 1'b0;
			all_pass_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						axis_q <= imuoc_pkg::AXIS_FIRST;
						if (action) begin
							// A start restarts any calibration already running.
							cnt_q      <= '0;
							active_q   <= 1'b1;
							first_q    <= 1'b1;
							finished_q <= 1'b0;
						end else begin
							state_q <= ST_CORR;
						end
					end
				end
				ST_CORR: begin
					if (axis_q == imuoc_pkg::AXIS_LAST) begin
						state_q <= ST_COUNT;
					end else begin
						axis_q <= axis_q + 1'b1;
					end
				end
				ST_COUNT: begin
					axis_q     <= imuoc_pkg::AXIS_FIRST;
					all_pass_q <= 1'b1;
					if (active_q && round_end) begin
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end else begin
						if (active_q) begin
							cnt_q <= cnt_inc[imuoc_pkg::CNT_W-1:0];
						end
						state_q <= ST_DELIVER;
					end
				end
				ST_DIV: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (div_done) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					all_pass_q <= all_pass_q && pass;
					if (axis_q == imuoc_pkg::AXIS_LAST) begin
						// Passing is only judged from the second round onwards.
						if (!first_q && all_pass_q && pass) begin
							active_q   <= 1'b0;
							finished_q <= 1'b1;
						end
						first_q <= 1'b0;
						state_q <= ST_DELIVER;
					end else begin
						axis_q  <= axis_q + 1'b1;
						state_q <= ST_DIV;
					end
				end
				ST_DELIVER: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register: holds one finished result until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_corr_q <= corr;
			out_cal_q  <= active_q;
			out_done_q <= finished_q;
		end
	end

	imuoc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.raw_in    (raw_in),
		.accel_tol (accel_tol_q),
		.gyro_tol  (gyro_tol_q),
		.grav      (grav_q),
		.quo       (quo),
		.corr      (corr),
		.sum_mag   (sum_mag),
		.pass      (pass)
	);

	imuoc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_mag),
		.done     (div_done),
		.quo      (quo)
	);

	assign out_valid        = out_valid_q;
	assign corr_accel_x     = out_corr_q[0];
	assign corr_accel_y     = out_corr_q[1];
	assign corr_accel_z     = out_corr_q[2];
	assign corr_gyro_x      = out_corr_q[3];
	assign corr_gyro_y      = out_corr_q[4];
	assign corr_gyro_z      = out_corr_q[5];
	assign calibrating      = out_cal_q;
	assign calibration_done = out_done_q;

	// A calibration cannot be both running and finished.
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(active_q && finished_q))
		else $error("calibration running and finished at once");

	// The offset update only follows a completed division.
	a_upd_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD) |-> $past(div_done))
		else $error("offset update without a finished division");

	// The round count always stays below the round length.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, cnt_q} < imuoc_pkg::ROUND_LEN))
		else $error("round count out of range");

	// A start transaction opens a first round at once.
	a_start_sets: assert property (@(posedge clk) disable iff (!arst_n)
		(in_take && action) |=> (active_q && first_q && !finished_q && cnt_q == '0))
		else $error("start did not open a calibration");

	// A result is never overwritten before it has been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !out_load)
		else $error("output register overwritten while held");

endmodule
